@@ hw/rtl/mrc_pkg.sv @@
// Package for the Modbus RTU response checker: op and status codes,
// the frame event struct and the CRC-16/Modbus byte update.
// No dependencies.
`default_nettype none

package mrc_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_CRC     = 2'd1;
	localparam logic [1:0] STS_HDR     = 2'd2;
	localparam logic [1:0] STS_TIMEOUT = 2'd3;

	localparam logic [1:0] REG_SLAVE   = 2'd0;
	localparam logic [1:0] REG_FUNC    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0]  RST_SLAVE   = 8'h01;
	localparam logic [7:0]  RST_FUNC    = 8'h04;
	localparam logic [15:0] RST_TIMEOUT = 16'd1000;

	// Frame event: raised when an item closes a frame or times it out
	typedef struct packed {
		logic       fire;
		logic [1:0] status;
		logic [5:0] count;
	} evt_t;

	// CRC-16/Modbus, reflected, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mrc_frame.sv @@
// Frame state of the response checker: byte store, running CRC, tick
// counter and the end-of-frame checks. Depends on mrc_pkg.
`default_nettype none

module mrc_frame
	import mrc_pkg::*;
#(
	parameter int REG_COUNT = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic [1:0]                 op,
	input  wire logic [7:0]                 rx_byte,
	input  wire logic [7:0]                 slave_address,
	input  wire logic [7:0]                 function_code,
	input  wire logic [15:0]                timeout_ticks,
	output evt_t                            evt,
	output logic      [REG_COUNT-1:0][15:0] words
);

	localparam int FRAME_LEN = 5 + 2 * REG_COUNT;
	localparam int STORE_LEN = FRAME_LEN - 2;

	logic        waiting_q;
	logic [5:0]  count_q;
	logic [15:0] crc_q;
	logic [15:0] elapsed_q;
	logic [7:0]  crc_lo_q;
	logic [7:0]  store_q [STORE_LEN];

	logic [15:0] tick_nxt;
	logic        hdr_ok;
	logic        is_byte;

	assign tick_nxt = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
	assign hdr_ok   = (store_q[0] == slave_address) && (store_q[1] == function_code)
			&& (store_q[2] == 8'(2 * REG_COUNT));
	assign is_byte  = adv && waiting_q && (op == OP_BYTE);

	always_comb begin
		evt.fire   = 1'b0;
		evt.status = STS_OK;
		evt.count  = count_q;
		unique case (op)
			OP_BYTE: begin
				if (waiting_q && count_q == 6'(FRAME_LEN - 1)) begin
					evt.fire  = adv;
					evt.count = 6'(FRAME_LEN);
					if ({rx_byte, crc_lo_q} != crc_q) begin
						evt.status = STS_CRC;
					end else if (!hdr_ok) begin
						evt.status = STS_HDR;
					end
				end
			end
			OP_TICK: begin
				if (waiting_q && tick_nxt >= timeout_ticks) begin
					evt.fire   = adv;
					evt.status = STS_TIMEOUT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			count_q   <= '0;
			crc_q     <= CRC_INIT;
			elapsed_q <= '0;
		end else if (adv) begin
			if (op == OP_START) begin
				waiting_q <= 1'b1;
				count_q   <= '0;
				crc_q     <= CRC_INIT;
				elapsed_q <= '0;
			end else if (waiting_q && op == OP_BYTE) begin
				count_q <= count_q + 6'd1;
				if (count_q < 6'(STORE_LEN)) begin
					crc_q <= crc16_byte(crc_q, rx_byte);
				end
				if (count_q == 6'(FRAME_LEN - 1)) begin
					waiting_q <= 1'b0;
				end
			end else if (waiting_q && op == OP_TICK) begin
				elapsed_q <= tick_nxt;
				if (tick_nxt >= timeout_ticks) begin
					waiting_q <= 1'b0;
				end
			end
		end
	end

	// CRC low byte is held apart; the high byte is compared as it arrives
	always_ff @(posedge clk) begin
		if (is_byte && count_q == 6'(STORE_LEN)) begin
			crc_lo_q <= rx_byte;
		end
	end

	for (genvar i = 0; i < STORE_LEN; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (is_byte && count_q == 6'(i)) begin
				store_q[i] <= rx_byte;
			end
		end
	end

	for (genvar k = 0; k < REG_COUNT; k++) begin : g_words
		assign words[k] = {store_q[3 + 2 * k], store_q[4 + 2 * k]};
	end

endmodule

`default_nettype wire

@@ hw/rtl/mrc_out.sv @@
// Result register of the response checker: loads a frame event and
// plays out the register words of a good frame. Depends on mrc_pkg.
`default_nettype none

module mrc_out
	import mrc_pkg::*;
#(
	parameter int REG_COUNT = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire evt_t                       evt,
	input  wire logic [REG_COUNT-1:0][15:0] words,
	output logic                            take,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [1:0]                 status,
	output logic      [15:0]                word_value,
	output logic      [3:0]                 word_index,
	output logic      [5:0]                 bytes_received,
	output logic                            last
);

	localparam logic [3:0] LAST_IDX = 4'(REG_COUNT - 1);

	logic        valid_q;
	logic        burst_q;
	logic [1:0]  status_q;
	logic [15:0] value_q;
	logic [3:0]  idx_q;
	logic [5:0]  count_q;
	logic        last_q;

	logic        slot_free;
	logic [3:0]  idx_nxt;
	logic [15:0] word_nxt;

	assign slot_free = !valid_q || out_ready;
	assign take      = slot_free && !burst_q;
	assign idx_nxt   = idx_q + 4'd1;

	always_comb begin
		word_nxt = '0;
		for (int k = 0; k < REG_COUNT; k++) begin
			if (idx_nxt == 4'(k)) begin
				word_nxt = words[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
		end else if (slot_free) begin
			if (burst_q) begin
				valid_q <= 1'b1;
				burst_q <= (idx_nxt != LAST_IDX);
			end else begin
				valid_q <= evt.fire;
				burst_q <= evt.fire && (evt.status == STS_OK) && (REG_COUNT > 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (burst_q) begin
				value_q <= word_nxt;
				idx_q   <= idx_nxt;
				last_q  <= (idx_nxt == LAST_IDX);
			end else if (evt.fire) begin
				status_q <= evt.status;
				count_q  <= evt.count;
				idx_q    <= '0;
				if (evt.status == STS_OK) begin
					value_q <= words[0];
					last_q  <= (REG_COUNT == 1);
				end else begin
					value_q <= '0;
					last_q  <= 1'b1;
				end
			end
		end
	end

	assign out_valid      = valid_q;
	assign status         = status_q;
	assign word_value     = value_q;
	assign word_index     = idx_q;
	assign bytes_received = count_q;
	assign last           = last_q;

`ifndef SYNTHESIS
	a_burst_shows_word: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> valid_q && !last_q && status_q == STS_OK)
		else $error("burst running without a non-final word on show");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q != STS_OK |-> last_q && idx_q == 4'd0 && value_q == 16'd0)
		else $error("error result not final or not cleared");

	a_word_steps: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q && slot_free |=> idx_q == $past(idx_q) + 4'd1)
		else $error("word index did not step during burst");

	a_no_take_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> !take)
		else $error("frame event taken while words still pending");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/modbus_rtu_response_checker_unit.sv @@
// Modbus RTU read-input-registers response checker, top level.
// Depends on mrc_pkg, mrc_frame and mrc_out.
//
// Usage: send a start item (op 0), then the response bytes (op 1) and
// millisecond ticks (op 2). CRC-16/Modbus runs over all but the last two
// bytes; once 5+2*REG_COUNT bytes are in, the frame is checked for CRC
// (low byte first), then slave id, function code and byte count. A good
// frame gives REG_COUNT results, one big-endian word each, the last marked;
// a failure or a timeout gives one status result with last set. Bytes and
// ticks while idle are ignored. Throughput is one item per cycle: an input
// register feeds a single pass of frame logic into the result register.
// Input is held while a result waits on out_ready, and after a good frame
// while its remaining words leave the result register one per cycle.
// Configuration (write enable, index, data) should be written while
// idle; unknown indexes are ignored.
`default_nettype none

module modbus_rtu_response_checker_unit
	import mrc_pkg::*;
#(
	parameter int REG_COUNT = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [15:0] wr_data,
	// input items
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  rx_byte,
	// result items
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  status,
	output logic      [15:0] word_value,
	output logic      [3:0]  word_index,
	output logic      [5:0]  bytes_received,
	output logic             last
);

	// configuration registers
	logic [7:0]  slave_q;
	logic [7:0]  func_q;
	logic [15:0] timeout_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;

	logic        take;
	logic        adv;
	evt_t        evt;
	logic [REG_COUNT-1:0][15:0] words;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_q   <= RST_SLAVE;
			func_q    <= RST_FUNC;
			timeout_q <= RST_TIMEOUT;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SLAVE:   slave_q   <= wr_data[7:0];
				REG_FUNC:    func_q    <= wr_data[7:0];
				REG_TIMEOUT: timeout_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// The input register frees as soon as its item is processed
	assign adv      = valid_s1 && take;
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	mrc_frame #(
		.REG_COUNT(REG_COUNT)
	) u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.op            (op_s1),
		.rx_byte       (byte_s1),
		.slave_address (slave_q),
		.function_code (func_q),
		.timeout_ticks (timeout_q),
		.evt           (evt),
		.words         (words)
	);

	mrc_out #(
		.REG_COUNT(REG_COUNT)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.evt            (evt),
		.words          (words),
		.take           (take),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.word_value     (word_value),
		.word_index     (word_index),
		.bytes_received (bytes_received),
		.last           (last)
	);

`ifndef SYNTHESIS
	a_evt_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		evt.fire |-> adv)
		else $error("frame event without an item being processed");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(op_s1) && $stable(byte_s1))
		else $error("input stage lost a stalled item");

	a_evt_count: assert property (@(posedge clk) disable iff (!arst_n)
		evt.fire && evt.status != STS_TIMEOUT |-> evt.count == 6'(5 + 2 * REG_COUNT))
		else $error("frame checked before it was complete");
`endif

endmodule

`default_nettype wire
